@@ sv/sorted_descending_priority_queue_macros.svh @@
// Assertion macros shared by the priority queue RTL.
// No dependencies; included inside module bodies after the package import.
`ifndef SORTED_DESCENDING_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_DESCENDING_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SDPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SDPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sdpq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types
// for the sorted descending priority queue. No dependencies.
`default_nettype none

package sdpq_pkg;

    // Default number of queue slots
    localparam int DEPTH_DEF = 8;

    // Field widths fixed by the interface
    localparam int VAL_W  = 32;
    localparam int OCC_W  = 4;
    localparam int STAT_W = 2;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic push;  // insert the request value in sorted position
        logic pop;   // remove the head entry
        logic load;  // capture result fields
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ sv/sorted_descending_priority_queue.sv @@
// Top level of the sorted descending priority queue: joins the controller
// and the slot datapath. Uses sdpq_pkg, sdpq_ctrl and sdpq_dp.
//
//  channel   handshake        payload
//  request   start / busy     i_func, i_value
//  result    o_strobe         o_status, o_removed_value, o_occupancy, o_top_value
//
// A request is taken whenever start is high; every slot compares with the value in parallel,
// so a new request may follow on every clock and busy stays low.
// Its result appears on the cycle after acceptance, strobed for exactly one cycle.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
// The result side cannot stall; each result must be taken when strobed.
`default_nettype none

module sorted_descending_priority_queue #(
    parameter int DEPTH = sdpq_pkg::DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 i_func,
    input  wire signed [sdpq_pkg::VAL_W-1:0]    i_value,
    output logic                                o_strobe,
    output logic [sdpq_pkg::STAT_W-1:0]         o_status,
    output logic signed [sdpq_pkg::VAL_W-1:0]   o_removed_value,
    output logic [sdpq_pkg::OCC_W-1:0]          o_occupancy,
    output logic signed [sdpq_pkg::VAL_W-1:0]   o_top_value
);
    import sdpq_pkg::*;

    t_dp_cmd  w_dp_cmd;
    t_dp_stat w_dp_stat;
    logic     w_accept;

    // Take a request on every start; the slots settle in the same cycle
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    sdpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_func    (i_func),
        .i_dp_stat (w_dp_stat),
        .o_dp_cmd  (w_dp_cmd),
        .o_strobe  (o_strobe),
        .o_status  (o_status)
    );

    sdpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (w_dp_cmd),
        .i_value         (i_value),
        .o_dp_stat       (w_dp_stat),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy),
        .o_top_value     (o_top_value)
    );

endmodule

`default_nettype wire

@@ sv/sdpq_ctrl.sv @@
// Controller of the priority queue: decodes requests into datapath
// commands, forms the status code and times the result strobe. Uses sdpq_pkg.
`default_nettype none

module sdpq_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  wire                          i_func,
    input  sdpq_pkg::t_dp_stat           i_dp_stat,
    output sdpq_pkg::t_dp_cmd            o_dp_cmd,
    output logic                         o_strobe,
    output logic [sdpq_pkg::STAT_W-1:0]  o_status
);
    import sdpq_pkg::*;

    `include "sorted_descending_priority_queue_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [STAT_W-1:0]   r_status, n_status;
    t_dp_cmd             w_cmd;

    // Decode the request against the current fill state
    always_comb begin
        w_cmd.push = i_accept && (i_func == OP_ENQ) && !i_dp_stat.full;
        w_cmd.pop  = i_accept && (i_func == OP_DEQ) && !i_dp_stat.empty;
        w_cmd.load = i_accept;
    end

    // Pick the status code for the request
    always_comb begin
        n_status = r_status;
        if (i_accept) begin
            unique case (i_func)
                OP_ENQ:  n_status = i_dp_stat.full  ? ST_OVERFLOW  : ST_OK;
                OP_DEQ:  n_status = i_dp_stat.empty ? ST_UNDERFLOW : ST_OK;
                default: n_status = ST_OK;
            endcase
        end
    end

    // Show a result in the cycle after each accepted request
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = i_accept ? S_RESP : S_IDLE;
            S_RESP:  n_state = i_accept ? S_RESP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign o_dp_cmd = w_cmd;
    assign o_strobe = (r_state == S_RESP);
    assign o_status = r_status;

    `SDPQ_ASSERT_IMPL(a_no_push_and_pop, i_clk, i_rst_n, 1'b1, !(w_cmd.push && w_cmd.pop), "push and pop together")
    `SDPQ_ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, i_accept, o_strobe, "accepted request without result")
    `SDPQ_ASSERT_NEXT(a_overflow_only_full, i_clk, i_rst_n, i_accept && (i_func == OP_ENQ) && !i_dp_stat.full, o_status == ST_OK, "enqueue with room not reported ok")
    `SDPQ_ASSERT_NEXT(a_underflow_only_empty, i_clk, i_rst_n, i_accept && (i_func == OP_DEQ) && i_dp_stat.empty, o_status == ST_UNDERFLOW, "dequeue of empty queue not reported")

endmodule

`default_nettype wire

@@ sv/sdpq_dp.sv @@
// Datapath of the priority queue: the sorted slot registers with one
// comparator per slot, the fill count and the result registers. Uses sdpq_pkg.
`default_nettype none

module sdpq_dp #(
    parameter int DEPTH = sdpq_pkg::DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  sdpq_pkg::t_dp_cmd                   i_dp_cmd,
    input  wire signed [sdpq_pkg::VAL_W-1:0]    i_value,
    output sdpq_pkg::t_dp_stat                  o_dp_stat,
    output logic signed [sdpq_pkg::VAL_W-1:0]   o_removed_value,
    output logic [sdpq_pkg::OCC_W-1:0]          o_occupancy,
    output logic signed [sdpq_pkg::VAL_W-1:0]   o_top_value
);
    import sdpq_pkg::*;

    `include "sorted_descending_priority_queue_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [VAL_W-1:0] r_entry [DEPTH];
    logic signed [VAL_W-1:0] n_entry [DEPTH];
    logic [CW-1:0]           r_count, n_count;
    logic signed [VAL_W-1:0] r_removed, r_top;
    logic [CW+OCC_W-1:0]     w_count_ext;
    logic [DEPTH-1:0]        w_take;

    // Mark slots at or after the insertion point: empty or smaller than the value
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_take[k] = !(CW'(k) < r_count) || (i_value > r_entry[k]);
        end
    end

    // Form the next slot contents: shift down behind an insert, shift up on a pop
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_entry[k] = r_entry[k];
            if (i_dp_cmd.push && w_take[k] && (CW'(k) <= r_count)) begin
                if (k > 0 && w_take[(k > 0) ? k - 1 : 0]) begin
                    n_entry[k] = r_entry[(k > 0) ? k - 1 : 0];
                end else begin
                    n_entry[k] = i_value;
                end
            end else if (i_dp_cmd.pop && (k < DEPTH - 1)) begin
                n_entry[k] = r_entry[(k < DEPTH - 1) ? k + 1 : k];
            end
        end
    end

    // Advance the fill count
    always_comb begin
        priority if (i_dp_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_dp_cmd.pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            r_entry[k] <= n_entry[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Capture the result fields for the request
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_removed <= i_dp_cmd.pop ? r_entry[0] : '0;
            r_top     <= (n_count != '0) ? n_entry[0] : '0;
        end
    end

    // Occupancy reported modulo the field width
    assign w_count_ext = {{OCC_W{1'b0}}, r_count};

    assign o_dp_stat.full  = (r_count == CW'(DEPTH));
    assign o_dp_stat.empty = (r_count == '0);
    assign o_removed_value = r_removed;
    assign o_top_value     = r_top;
    assign o_occupancy     = w_count_ext[OCC_W-1:0];

    `SDPQ_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, i_dp_cmd.push, r_count < CW'(DEPTH), "push into full store")
    `SDPQ_ASSERT_IMPL(a_pop_has_entry, i_clk, i_rst_n, i_dp_cmd.pop, r_count != '0, "pop from empty store")
    `SDPQ_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, i_dp_cmd.push, r_count == $past(r_count) + CW'(1), "push did not grow count")
    `SDPQ_ASSERT_NEXT(a_pop_counts, i_clk, i_rst_n, i_dp_cmd.pop, r_count == $past(r_count) - CW'(1), "pop did not shrink count")

endmodule

`default_nettype wire

@@ tb/tb_sorted_descending_priority_queue.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sorted descending priority queue.
// Depends on sdpq_pkg and sorted_descending_priority_queue; a scoreboard class
// predicts each result from its own copy of the sorted store.
`default_nettype none

module tb_sorted_descending_priority_queue;
    import sdpq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int NUM_RANDOM  = 1650;
    localparam int CYCLE_LIMIT = 200000;

    // One result as seen on the result ports
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [VAL_W-1:0]  removed;
        logic [OCC_W-1:0]         occ;
        logic signed [VAL_W-1:0]  top;
    } t_pq_result;

    // Sorted-store predictor and result checker
    class pq_scoreboard;
        logic signed [VAL_W-1:0] slots [QDEPTH];
        int unsigned             fill;
        t_pq_result              expected_results [$];
        int unsigned             mismatches;

        // Apply one accepted request to the store and queue its result
        function void note_request(logic func, logic signed [VAL_W-1:0] value);
            t_pq_result  r;
            int unsigned idx;
            r.status  = ST_OK;
            r.removed = '0;
            if (func == OP_ENQ) begin
                if (fill >= QDEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    // shift every strictly smaller entry down, insert after equals
                    idx = fill;
                    while (idx > 0 && value > slots[idx-1]) begin
                        slots[idx] = slots[idx-1];
                        idx--;
                    end
                    slots[idx] = value;
                    fill++;
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.removed = slots[0];
                    for (int i = 1; i < fill; i++)
                        slots[i-1] = slots[i];
                    fill--;
                end
            end
            r.occ = fill[OCC_W-1:0];
            r.top = (fill > 0) ? slots[0] : '0;
            expected_results.push_back(r);
        endfunction

        // Compare one strobed result with the oldest expectation
        function void check_result(t_pq_result got);
            t_pq_result exp_r;
            if (expected_results.size() == 0) begin
                $error("result with no request pending: status=%0d removed=%0d",
                       got.status, got.removed);
                mismatches++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                mismatches++;
            end
            if (got.removed !== exp_r.removed) begin
                $error("removed_value: expected %0d, actual %0d", exp_r.removed, got.removed);
                mismatches++;
            end
            if (got.occ !== exp_r.occ) begin
                $error("occupancy: expected %0d, actual %0d", exp_r.occ, got.occ);
                mismatches++;
            end
            if (got.top !== exp_r.top) begin
                $error("top_value: expected %0d, actual %0d", exp_r.top, got.top);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_func = OP_ENQ;
    logic signed [VAL_W-1:0]  i_value = '0;
    logic                     o_strobe;
    logic [STAT_W-1:0]        o_status;
    logic signed [VAL_W-1:0]  o_removed_value;
    logic [OCC_W-1:0]         o_occupancy;
    logic signed [VAL_W-1:0]  o_top_value;

    pq_scoreboard sb = new;
    int unsigned  cycle_count = 0;

    sorted_descending_priority_queue #(.DEPTH(QDEPTH)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy),
        .o_top_value     (o_top_value)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Sample handshakes at each edge: check strobed results, note accepted requests
    always @(posedge i_clk) begin
        t_pq_result got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            got.status  = o_status;
            got.removed = o_removed_value;
            got.occ     = o_occupancy;
            got.top     = o_top_value;
            sb.check_result(got);
        end
        if (i_rst_n && start && !busy)
            sb.note_request(i_func, i_value);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Hold a request until the block takes it
    task automatic send_request(input logic func, input logic signed [VAL_W-1:0] value);
        start  <= 1'b1;
        i_func <= func;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start with junk on the payload; does nothing when n is zero
    task automatic idle_cycles(input int n);
        if (n == 0)
            return;
        start <= 1'b0;
        repeat (n) begin
            i_func  <= 1'($urandom);
            i_value <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // Mix of tight-range values for ties, extremes and full-width randoms
    function automatic logic signed [VAL_W-1:0] rand_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VAL_W'(int'($urandom_range(0, 8)) - 4);
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh7FFF_FFFE;
                    default: return 32'sh8000_0001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned enq_pct;
        int unsigned drain_wait;
        logic        func;

        // Hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: underflow on empty, extremes, ties, fill to overflow, drain
        send_request(OP_DEQ, 32'sh1234_5678);
        send_request(OP_ENQ, 32'sh7FFF_FFFF);
        send_request(OP_ENQ, 32'sh8000_0000);
        send_request(OP_ENQ, 32'sh0000_0000);
        send_request(OP_ENQ, -32'sd1);
        send_request(OP_ENQ, 32'sd1);
        send_request(OP_ENQ, 32'sd5);
        send_request(OP_ENQ, 32'sd5);
        send_request(OP_ENQ, 32'sd5);
        send_request(OP_ENQ, 32'sd7);
        send_request(OP_ENQ, 32'sh7FFF_FFFF);
        repeat (QDEPTH + 1)
            send_request(OP_DEQ, $urandom);
        idle_cycles(3);

        // Random bursts; bias per burst drifts the queue between empty and full
        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0: enq_pct = 30;
                1: enq_pct = 50;
                default: enq_pct = 75;
            endcase
            repeat (burst) begin
                func = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                send_request(func, rand_priority());
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                idle_cycles(0);
            else
                idle_cycles($urandom_range(1, 6));
        end
        start <= 1'b0;

        // Drain outstanding results, then keep sampling for strays
        drain_wait = 0;
        while (sb.expected_results.size() != 0 && drain_wait < 100) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (4) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (sb.expected_results.size() != 0)
                $error("%0d expected results never arrived", sb.expected_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
